### rtl/core/rhsl_pkg.sv
`default_nettype none

package rhsl_pkg;

  // Width of each color channel and of each result fraction.
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned FRAC_W = 16;

  // Divider operands: a 28-bit dividend, a divisor below 4096 and a
  // partial remainder that always stays below the divisor.
  localparam int unsigned NUM_W  = 28;
  localparam int unsigned DEN_W  = 12;
  localparam int unsigned REM_W  = DEN_W;

  // Hue numerator n lies below 6 * 255.
  localparam int unsigned HNUM_W = 11;
  localparam int unsigned SUM_W  = CHAN_W + 1;

  // Number of restoring divider steps, one quotient bit each.
  localparam int unsigned DIV_STEPS = FRAC_W;

  // Result of the classify stage.
  typedef struct packed {
    logic [CHAN_W-1:0] d;
    logic [HNUM_W-1:0] hnum;
    logic [CHAN_W-1:0] sden;
    logic [FRAC_W-1:0] lit;
  } cls_t;

  // One divider lane: remainder, dividend bits shifting out while the
  // quotient bits shift in, and the divisor.
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [FRAC_W-1:0] work;
    logic [DEN_W-1:0]  den;
  } lane_t;

  // Payload that travels down the divider pipeline.
  typedef struct packed {
    lane_t             hue;
    lane_t             sat;
    logic [FRAC_W-1:0] lit;
  } pipe_t;

endpackage

`default_nettype wire

### rtl/core/rhsl_classify.sv
`default_nettype none

module rhsl_classify (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      up_valid,
  output logic                           up_stall,
  input  wire logic [3*rhsl_pkg::CHAN_W-1:0] up_rgb,
  output logic                           dn_valid,
  input  wire logic                      dn_stall,
  output rhsl_pkg::cls_t                 dn_data
);

  logic [rhsl_pkg::CHAN_W-1:0] r, g, b;
  logic [rhsl_pkg::CHAN_W-1:0] mx, mn, mx_rg, mn_rg, d;
  logic [rhsl_pkg::SUM_W-1:0]  sum;
  logic [rhsl_pkg::SUM_W:0]    sum_p1;
  logic [rhsl_pkg::FRAC_W-1:0] lit;
  logic [rhsl_pkg::HNUM_W-1:0] d_w, r_w, g_w, b_w;
  logic                        valid_r;
  logic                        load;
  rhsl_pkg::cls_t              data_r, data_nxt;

  assign r = up_rgb[3*rhsl_pkg::CHAN_W-1:2*rhsl_pkg::CHAN_W];
  assign g = up_rgb[2*rhsl_pkg::CHAN_W-1:rhsl_pkg::CHAN_W];
  assign b = up_rgb[rhsl_pkg::CHAN_W-1:0];

  // Largest and smallest channel, their spread and their sum.
  always_comb begin
    mx_rg = (r > g) ? r : g;
    mx    = (mx_rg > b) ? mx_rg : b;
    mn_rg = (r < g) ? r : g;
    mn    = (mn_rg < b) ? mn_rg : b;
    d     = mx - mn;
    sum   = {1'b0, mx} + {1'b0, mn};
  end

  // Hue numerator over 6d, and the saturation denominator.
  always_comb begin
    d_w = rhsl_pkg::HNUM_W'(d);
    r_w = rhsl_pkg::HNUM_W'(r);
    g_w = rhsl_pkg::HNUM_W'(g);
    b_w = rhsl_pkg::HNUM_W'(b);
    if (r == mx) begin
      if (g >= b) begin
        data_nxt.hnum = g_w - b_w;
      end else begin
        data_nxt.hnum = (d_w << 2) + (d_w << 1) - (b_w - g_w);
      end
    end else if (g == mx) begin
      data_nxt.hnum = (d_w << 1) + b_w - r_w;
    end else begin
      data_nxt.hnum = (d_w << 2) + r_w - g_w;
    end
    data_nxt.d = d;
    if (sum < rhsl_pkg::SUM_W'(255)) begin
      data_nxt.sden = sum[rhsl_pkg::CHAN_W-1:0];
    end else begin
      data_nxt.sden = rhsl_pkg::CHAN_W'(rhsl_pkg::SUM_W'(510) - sum);
    end
    data_nxt.lit = lit;
  end

  // Lightness is sum * 128.5, so it is sum * 128 plus half the sum rounded up.
  always_comb begin
    sum_p1 = {1'b0, sum} + {{rhsl_pkg::SUM_W{1'b0}}, 1'b1};
    lit    = {sum, 7'b0} + {7'b0, sum_p1[rhsl_pkg::SUM_W:1]};
  end

  // Stage register; it refills whenever it is empty or its beat moves on.
  assign load     = !valid_r || !dn_stall;
  assign up_stall = !load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

### rtl/core/rhsl_operands.sv
`default_nettype none

module rhsl_operands (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           up_valid,
  output logic                up_stall,
  input  wire rhsl_pkg::cls_t up_data,
  output logic                dn_valid,
  input  wire logic           dn_stall,
  output rhsl_pkg::pipe_t     dn_data
);

  logic [rhsl_pkg::NUM_W-1:0] d_n, hn_n, sd_n, hue_num, sat_num;
  logic [rhsl_pkg::DEN_W-1:0] d_s;
  logic                       valid_r;
  logic                       load;
  rhsl_pkg::pipe_t            data_r, data_nxt;

  // Rounded quotient num / den is floor((2 * num + den) / (2 * den)),
  // with num = x * 65535 = (x << 16) - x.
  always_comb begin
    d_n  = rhsl_pkg::NUM_W'(up_data.d);
    hn_n = rhsl_pkg::NUM_W'(up_data.hnum);
    sd_n = rhsl_pkg::NUM_W'(up_data.sden);
    d_s  = rhsl_pkg::DEN_W'(up_data.d);
    hue_num = (hn_n << 17) - (hn_n << 1) + (d_n << 2) + (d_n << 1);
    sat_num = (d_n << 17) - (d_n << 1) + sd_n;
  end

  // Load both divider lanes; a grey pixel divides zero by one.
  always_comb begin
    data_nxt.lit = up_data.lit;
    if (up_data.d == '0) begin
      data_nxt.hue.rem  = '0;
      data_nxt.hue.work = '0;
      data_nxt.hue.den  = rhsl_pkg::DEN_W'(1);
      data_nxt.sat.rem  = '0;
      data_nxt.sat.work = '0;
      data_nxt.sat.den  = rhsl_pkg::DEN_W'(1);
    end else begin
      data_nxt.hue.rem  = hue_num[rhsl_pkg::NUM_W-1:rhsl_pkg::FRAC_W];
      data_nxt.hue.work = hue_num[rhsl_pkg::FRAC_W-1:0];
      data_nxt.hue.den  = (d_s << 3) + (d_s << 2);
      data_nxt.sat.rem  = sat_num[rhsl_pkg::NUM_W-1:rhsl_pkg::FRAC_W];
      data_nxt.sat.work = sat_num[rhsl_pkg::FRAC_W-1:0];
      data_nxt.sat.den  = {rhsl_pkg::DEN_W'(up_data.sden) << 1};
    end
  end

  // Stage register with bubble collapse.
  assign load     = !valid_r || !dn_stall;
  assign up_stall = !load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

### rtl/core/rhsl_div_step.sv
`default_nettype none

module rhsl_div_step (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  output logic                 up_stall,
  input  wire rhsl_pkg::pipe_t up_data,
  output logic                 dn_valid,
  input  wire logic            dn_stall,
  output rhsl_pkg::pipe_t      dn_data
);

  logic            valid_r;
  logic            load;
  rhsl_pkg::pipe_t data_r, data_nxt;

  // One restoring division step: bring down the next dividend bit and
  // subtract the divisor when it fits; the quotient bit shifts in below.
  function automatic rhsl_pkg::lane_t div_bit(input rhsl_pkg::lane_t ln);
    logic [rhsl_pkg::REM_W:0] t;
    logic [rhsl_pkg::REM_W:0] den_x;
    logic                     fit;
    rhsl_pkg::lane_t          res;
    t       = {ln.rem, ln.work[rhsl_pkg::FRAC_W-1]};
    den_x   = {1'b0, ln.den};
    fit     = (t >= den_x);
    res.den = ln.den;
    res.rem = fit ? rhsl_pkg::REM_W'(t - den_x) : rhsl_pkg::REM_W'(t);
    res.work = {ln.work[rhsl_pkg::FRAC_W-2:0], fit};
    return res;
  endfunction

  always_comb begin
    data_nxt.hue = div_bit(up_data.hue);
    data_nxt.sat = div_bit(up_data.sat);
    data_nxt.lit = up_data.lit;
  end

  // Stage register with bubble collapse.
  assign load     = !valid_r || !dn_stall;
  assign up_stall = !load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // The partial remainder must stay below a nonzero divisor in both lanes.
  a_hue_rem: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (data_r.hue.rem < data_r.hue.den))
    else $error("hue remainder not below divisor");

  a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (data_r.sat.rem < data_r.sat.den))
    else $error("saturation remainder not below divisor");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    up_stall |-> (valid_r && dn_stall))
    else $error("stage stalls upstream without a held beat");

endmodule

`default_nettype wire

### rtl/core/rgb_to_hsl_converter_core.sv
`default_nettype none

// Converts one packed RGB pixel (red 23..16, green 15..8, blue 7..0) per
// clock while nothing stalls into hue, saturation and lightness, each a
// fraction scaled by 65535 and rounded to nearest. The pipeline is 18
// register stages deep: one stage finds the largest and smallest channel,
// one forms the dividends, and 16 stages run two restoring dividers side
// by side, one quotient bit per stage. A pixel passes through the classify
// register, the operand register and the divider stages in that order, the
// last of which is the output register. Empty stages close up while the
// output is stalled, so the input keeps taking beats until every stage
// holds one.
module rgb_to_hsl_converter_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [3*rhsl_pkg::CHAN_W-1:0] in_rgb_color,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [rhsl_pkg::FRAC_W-1:0]      out_hue,
  output logic [rhsl_pkg::FRAC_W-1:0]      out_saturation,
  output logic [rhsl_pkg::FRAC_W-1:0]      out_lightness
);

  logic            cls_valid, cls_stall;
  rhsl_pkg::cls_t  cls_data;
  logic            stg_valid [rhsl_pkg::DIV_STEPS+1];
  logic            stg_stall [rhsl_pkg::DIV_STEPS+1];
  rhsl_pkg::pipe_t stg_data  [rhsl_pkg::DIV_STEPS+1];

  // Channel compare and hue numerator selection.
  rhsl_classify u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_rgb   (in_rgb_color),
    .dn_valid (cls_valid),
    .dn_stall (cls_stall),
    .dn_data  (cls_data)
  );

  // Dividend and divisor formation.
  rhsl_operands u_operands (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (cls_valid),
    .up_stall (cls_stall),
    .up_data  (cls_data),
    .dn_valid (stg_valid[0]),
    .dn_stall (stg_stall[0]),
    .dn_data  (stg_data[0])
  );

  // Divider pipeline, one quotient bit per stage.
  for (genvar i = 0; i < rhsl_pkg::DIV_STEPS; i++) begin : g_div
    rhsl_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[i]),
      .up_stall (stg_stall[i]),
      .up_data  (stg_data[i]),
      .dn_valid (stg_valid[i+1]),
      .dn_stall (stg_stall[i+1]),
      .dn_data  (stg_data[i+1])
    );
  end

  // The last stage is the output register.
  assign stg_stall[rhsl_pkg::DIV_STEPS] = out_stall;
  assign out_valid      = stg_valid[rhsl_pkg::DIV_STEPS];
  assign out_hue        = stg_data[rhsl_pkg::DIV_STEPS].hue.work;
  assign out_saturation = stg_data[rhsl_pkg::DIV_STEPS].sat.work;
  assign out_lightness  = stg_data[rhsl_pkg::DIV_STEPS].lit;

endmodule

`default_nettype wire
